### sv/ita_pkg.sv
// shared types, codes and character constants for the integer-to-ascii formatter
// no dependencies; imported by every module of the block
package ita_pkg;

    // ascii codes used by the formatter
    localparam logic [6:0] CHR_ZERO   = 7'd48;
    localparam logic [6:0] CHR_LETTER = 7'd65;
    localparam logic [6:0] CHR_MINUS  = 7'd45;

    // format selector codes
    typedef enum logic [1:0] {
        ACT_UDEC = 2'd0,
        ACT_SDEC = 2'd1,
        ACT_HEX  = 2'd2,
        ACT_BIN  = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMITD,
        ST_EMITB
    } state_t;

    // operations of the shared shift unit
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD_BIN,
        OP_LOAD_HEX,
        OP_DABBLE,
        OP_SHIFT_DIGIT
    } unit_op_t;

    // one character handed to the output register
    typedef struct packed {
        logic       push;
        logic [6:0] character;
        logic       last;
    } emit_t;

    // decimal digits needed for a value of w bits (1233/4096 ~ log10 2)
    function automatic int ita_ndig(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    // ascii for one decimal or hex digit, upper-case letters
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] ch;
        if (d < 4'd10)
            ch = CHR_ZERO + 7'(d);
        else
            ch = CHR_LETTER + 7'(d) - 7'd10;
        return ch;
    endfunction

endpackage

### sv/ita_shift_unit.sv
// shared shift unit: double-dabble binary to bcd, hex digit load, digit shift-out
// depends on ita_pkg
module ita_shift_unit
    import ita_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  unit_op_t               op,
    input  logic [VALUE_WIDTH-1:0] load_data,
    output logic [3:0]             top_digit
);

    localparam int NDIG = ita_ndig(VALUE_WIDTH);
    localparam int DW   = 4 * NDIG;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [DW-1:0]          bcd_reg;
    logic [DW-1:0]          bcd_next;
    logic [DW-1:0]          bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int j = 0; j < NDIG; j++)
        begin
            if (bcd_reg[4*j +: 4] >= 4'd5)
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4] + 4'd3;
            else
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4];
        end
    end

    // operation select
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        unique case (op)
            OP_HOLD:
            begin
                bin_next = bin_reg;
                bcd_next = bcd_reg;
            end
            OP_LOAD_BIN:
            begin
                bin_next = load_data;
                bcd_next = '0;
            end
            OP_LOAD_HEX:
            begin
                bcd_next = DW'(load_data);
            end
            OP_DABBLE:
            begin
                bcd_next = {bcd_adj[DW-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            OP_SHIFT_DIGIT:
            begin
                bcd_next = {bcd_reg[DW-5:0], 4'd0};
            end
            default:
            begin
                bin_next = bin_reg;
                bcd_next = bcd_reg;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[DW-1 -: 4];

endmodule

### sv/ita_out_reg.sv
// output register stage for the character channel
// depends on ita_pkg
module ita_out_reg
    import ita_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_t      emit,
    input  logic       out_stall,
    output logic       ready,
    output logic       out_valid,
    output logic [6:0] character,
    output logic       last
);

    logic       valid_reg;
    logic       valid_next;
    logic [6:0] char_reg;
    logic       last_reg;

    // room for a new character when empty or the held one leaves now
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (emit.push)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            char_reg <= emit.character;
            last_reg <= emit.last;
        end
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

### sv/integer_to_ascii_formatter.sv
// integer-to-ascii formatter top level: sequencer, shift unit and output register
// depends on ita_pkg, ita_shift_unit, ita_out_reg
//
// usage:
//   input channel (in_valid / in_stall) takes action, value and top_bit; the value is
//   used at VALUE_WIDTH bits. output channel (out_valid / out_stall) gives one ascii
//   character per transfer, most significant first, with last set on the final one.
//   in_stall is high from the accepting edge until the final character has entered
//   the output register; one value is in work at a time.
//   decimal: a load, one double-dabble shift per value bit in the shared shift
//   unit, a minus sign when negative, then leading zeros are skipped and the
//   significant digits emitted, most significant first.
//   hex: a load, then leading zeros are skipped and the significant digits emitted.
//   binary: a load, then top_bit+1 characters at one per cycle unless out_stall holds.
//   the output register holds one character; a new one enters at the edge where the
//   held one leaves, so a stalled receiver pauses the sequencer and nothing is lost.
//   reset clears the sequencer and the output valid; no value is in work after it.
module integer_to_ascii_formatter
    import ita_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] value,
    input  logic [4:0]  top_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  character,
    output logic        last
);

    localparam int NDIG = ita_ndig(VALUE_WIDTH);
    localparam int CW   = $clog2(VALUE_WIDTH + 1);
    localparam int GW   = $clog2(NDIG + 1);

    state_t                 state_reg;
    state_t                 state_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [CW-1:0]          dab_cnt_reg;
    logic [CW-1:0]          dab_cnt_next;
    logic [GW-1:0]          dig_cnt_reg;
    logic [GW-1:0]          dig_cnt_next;
    logic [4:0]             bit_cnt_reg;
    logic [4:0]             bit_cnt_next;
    logic [31:0]            bits_reg;
    logic [31:0]            bits_next;

    logic [VALUE_WIDTH-1:0] val_w;
    logic [VALUE_WIDTH-1:0] mag;
    logic [31:0]            bits_in;
    logic                   sign_neg;
    logic                   accept;
    logic                   ready;
    logic [3:0]             top_digit;
    unit_op_t               op;
    emit_t                  emit;

    // value at the configured width
    generate
        if (VALUE_WIDTH <= 32)
        begin : g_narrow
            assign val_w = value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign val_w = {{(VALUE_WIDTH-32){1'b0}}, value};
        end
    endgenerate

    // binary view: bits above the value width print as zero
    generate
        for (genvar i = 0; i < 32; i++)
        begin : g_bits
            if (i < VALUE_WIDTH)
            begin : g_in
                assign bits_in[i] = val_w[i];
            end
            else
            begin : g_out
                assign bits_in[i] = 1'b0;
            end
        end
    endgenerate

    // magnitude for signed decimal
    assign sign_neg = (action_t'(action) == ACT_SDEC) && val_w[VALUE_WIDTH-1];
    assign mag      = sign_neg ? (~val_w + VALUE_WIDTH'(1)) : val_w;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action_t'(action))
                        ACT_UDEC, ACT_SDEC: state_next = ST_CONV;
                        ACT_HEX:            state_next = ST_SKIP;
                        ACT_BIN:            state_next = ST_EMITB;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (dab_cnt_reg == CW'(1))
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
            end
            ST_SIGN:
            begin
                if (ready)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (!(dig_cnt_reg > GW'(1) && top_digit == 4'd0))
                    state_next = ST_EMITD;
            end
            ST_EMITD:
            begin
                if (ready && dig_cnt_reg == GW'(1))
                    state_next = ST_IDLE;
            end
            ST_EMITB:
            begin
                if (ready && bit_cnt_reg == 5'd0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: unit operation, counters and character pushes
    always_comb
    begin
        op             = OP_HOLD;
        emit.push      = 1'b0;
        emit.character = CHR_ZERO;
        emit.last      = 1'b0;
        neg_next       = neg_reg;
        dab_cnt_next   = dab_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        bits_next      = bits_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = sign_neg;
                    dab_cnt_next = CW'(VALUE_WIDTH);
                    dig_cnt_next = GW'(NDIG);
                    bit_cnt_next = top_bit;
                    bits_next    = bits_in;
                    unique case (action_t'(action))
                        ACT_UDEC, ACT_SDEC: op = OP_LOAD_BIN;
                        ACT_HEX:            op = OP_LOAD_HEX;
                        ACT_BIN:            op = OP_HOLD;
                        default:            op = OP_HOLD;
                    endcase
                end
            end
            ST_CONV:
            begin
                op           = OP_DABBLE;
                dab_cnt_next = dab_cnt_reg - CW'(1);
            end
            ST_SIGN:
            begin
                if (ready)
                begin
                    emit.push      = 1'b1;
                    emit.character = CHR_MINUS;
                    neg_next       = 1'b0;
                end
            end
            ST_SKIP:
            begin
                if (dig_cnt_reg > GW'(1) && top_digit == 4'd0)
                begin
                    op           = OP_SHIFT_DIGIT;
                    dig_cnt_next = dig_cnt_reg - GW'(1);
                end
            end
            ST_EMITD:
            begin
                if (ready)
                begin
                    emit.push      = 1'b1;
                    emit.character = digit_char(top_digit);
                    emit.last      = (dig_cnt_reg == GW'(1));
                    op             = OP_SHIFT_DIGIT;
                    dig_cnt_next   = dig_cnt_reg - GW'(1);
                end
            end
            ST_EMITB:
            begin
                if (ready)
                begin
                    emit.push      = 1'b1;
                    emit.character = CHR_ZERO | {6'd0, bits_reg[bit_cnt_reg]};
                    emit.last      = (bit_cnt_reg == 5'd0);
                    bit_cnt_next   = bit_cnt_reg - 5'd1;
                end
            end
            default:
            begin
                op = OP_HOLD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // work registers
    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        dab_cnt_reg <= dab_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        bit_cnt_reg <= bit_cnt_next;
        bits_reg    <= bits_next;
    end

    // shared shift unit
    ita_shift_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_shift_unit (
        .clk       (clk),
        .op        (op),
        .load_data (mag),
        .top_digit (top_digit)
    );

    // output register
    ita_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_stall (out_stall),
        .ready     (ready),
        .out_valid (out_valid),
        .character (character),
        .last      (last)
    );

endmodule
